/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the serial frame receiver
// Event modes, reply codes, send events, register indexes and the
// control structures that pass between the receive and send sections.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_SENT = 2'd2;

   localparam logic [7:0] REPLY_CRC_BAD   = 8'd0;
   localparam logic [7:0] REPLY_TIMEOUT   = 8'd2;
   localparam logic [7:0] REPLY_BAD_START = 8'd3;
   localparam logic [7:0] REPLY_GOOD      = 8'd255;

   localparam logic [7:0] BYTE_RESEND = 8'd0;
   localparam logic [7:0] BYTE_ACK    = 8'd255;
   localparam logic [7:0] LEN_FLOOR   = 8'd3;

   localparam logic [1:0] SEND_EV_NONE    = 2'd0;
   localparam logic [1:0] SEND_EV_RESEND  = 2'd1;
   localparam logic [1:0] SEND_EV_SUCCESS = 2'd2;
   localparam logic [1:0] SEND_EV_FAIL    = 2'd3;

   localparam logic [1:0] CSR_MIN_LEN   = 2'd0;
   localparam logic [1:0] CSR_MAX_LEN   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_RETRY_LIM = 2'd3;

   localparam logic [7:0]  MIN_LEN_RESET   = 8'd10;
   localparam logic [7:0]  MAX_LEN_RESET   = 8'd66;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [3:0]  RETRY_LIM_RESET = 4'd3;

   localparam logic [7:0]  CRC_BYTES = 8'd2;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_code;
      logic       write_valid;
      logic [7:0] write_index;
      logic [7:0] write_byte;
      logic       frame_done;
      logic       frame_good;
   } rx_result_type;

   typedef struct packed {
      logic tick;
      logic sent;
      logic resend;
      logic ack;
   } tx_request_type;

endpackage

/* rtl/sfr_crc.sv */
// ----------------------------------------------------------------------------
// sfr_crc: one-byte CRC-16 update
// Reflected polynomial 0xA001, eight bit steps on a 16-bit value.
// ----------------------------------------------------------------------------
module sfr_crc (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import sfr_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {8'd0, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

/* rtl/sfr_rx.sv */
// ----------------------------------------------------------------------------
// sfr_rx: frame receive section
// Tracks position within a length-prefixed frame, runs the CRC over the
// body, checks the trailing CRC and times out a stalled frame.
// ----------------------------------------------------------------------------
module sfr_rx (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            mode,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            min_len,
   input  logic [7:0]            max_len,
   input  logic [15:0]           timeout_ticks,
   output logic                  pos_zero,
   output sfr_pkg::rx_result_type result
);
   import sfr_pkg::*;

   logic [7:0]  position_ff, position_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic        receiving_ff, receiving_in;
   logic [15:0] receive_timer_ff, receive_timer_in;

   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [7:0]  len_eff;
   logic [7:0]  body;

   assign pos_zero = (position_ff == 8'd0);
   assign crc_base = pos_zero ? 16'd0 : running_crc_ff;
   assign len_eff  = pos_zero ? rx_byte : frame_length_ff;
   assign body     = len_eff - CRC_BYTES;

   sfr_crc u_crc (
      .crc_in  (crc_base),
      .data_in (rx_byte),
      .crc_out (crc_next)
   );

   always_comb begin
      logic build;
      build            = 1'b0;
      result           = '0;
      position_in      = position_ff;
      frame_length_in  = frame_length_ff;
      running_crc_in   = running_crc_ff;
      crc_high_in      = crc_high_ff;
      receiving_in     = receiving_ff;
      receive_timer_in = receive_timer_ff;
      if (accept) begin
         case (mode)
            MODE_BYTE: begin
               build = 1'b1;
               if (pos_zero) begin
                  build = 1'b0;
                  if (rx_byte == BYTE_RESEND || rx_byte == BYTE_ACK) begin
                     // handled by the send section
                  end else if (rx_byte < LEN_FLOOR || rx_byte < min_len ||
                               rx_byte > max_len) begin
                     result.reply_valid = 1'b1;
                     result.reply_code  = REPLY_BAD_START;
                  end else begin
                     receiving_in     = 1'b1;
                     receive_timer_in = 16'd0;
                     frame_length_in  = rx_byte;
                     build            = 1'b1;
                  end
               end
               if (build) begin
                  result.write_valid = 1'b1;
                  result.write_index = position_ff;
                  result.write_byte  = rx_byte;
                  if (position_ff < body) begin
                     running_crc_in = crc_next;
                     position_in    = position_ff + 8'd1;
                  end else if (position_ff == body) begin
                     crc_high_in = rx_byte;
                     position_in = position_ff + 8'd1;
                  end else begin
                     result.reply_valid = 1'b1;
                     result.frame_done  = 1'b1;
                     if ({crc_high_ff, rx_byte} == running_crc_ff) begin
                        result.reply_code = REPLY_GOOD;
                        result.frame_good = 1'b1;
                     end else begin
                        result.reply_code = REPLY_CRC_BAD;
                     end
                     receiving_in = 1'b0;
                     position_in  = 8'd0;
                  end
               end
            end
            MODE_TICK: begin
               if (receiving_ff) begin
                  if (receive_timer_ff >= timeout_ticks) begin
                     result.reply_valid = 1'b1;
                     result.reply_code  = REPLY_TIMEOUT;
                     result.frame_done  = 1'b1;
                     receiving_in       = 1'b0;
                     position_in        = 8'd0;
                  end else begin
                     receive_timer_in = receive_timer_ff + 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         frame_length_ff  <= '0;
         running_crc_ff   <= '0;
         crc_high_ff      <= '0;
         receiving_ff     <= 1'b0;
         receive_timer_ff <= '0;
      end else begin
         position_ff      <= position_in;
         frame_length_ff  <= frame_length_in;
         running_crc_ff   <= running_crc_in;
         crc_high_ff      <= crc_high_in;
         receiving_ff     <= receiving_in;
         receive_timer_ff <= receive_timer_in;
      end
   end

endmodule

/* rtl/sfr_tx.sv */
// ----------------------------------------------------------------------------
// sfr_tx: send supervision
// Watches the pending outgoing frame: resend requests, acknowledge,
// send timeout with a bounded number of retries.
// ----------------------------------------------------------------------------
module sfr_tx (
   input  logic                   clock,
   input  logic                   reset,
   input  sfr_pkg::tx_request_type req,
   input  logic [15:0]            timeout_ticks,
   input  logic [3:0]             retry_limit,
   output logic [1:0]             send_event
);
   import sfr_pkg::*;

   logic        sending_ff, sending_in;
   logic [15:0] send_timer_ff, send_timer_in;
   logic [4:0]  retry_count_ff, retry_count_in;
   logic [4:0]  retry_inc;

   assign retry_inc = retry_count_ff + 5'd1;

   always_comb begin
      send_event     = SEND_EV_NONE;
      sending_in     = sending_ff;
      send_timer_in  = send_timer_ff;
      retry_count_in = retry_count_ff;
      if (req.resend && sending_ff) begin
         send_event = SEND_EV_RESEND;
      end
      if (req.ack && sending_ff) begin
         send_event = SEND_EV_SUCCESS;
         sending_in = 1'b0;
      end
      if (req.tick && sending_ff) begin
         if (send_timer_ff >= timeout_ticks) begin
            retry_count_in = retry_inc;
            if (retry_inc <= {1'b0, retry_limit}) begin
               send_event    = SEND_EV_RESEND;
               send_timer_in = 16'd0;
            end else begin
               send_event = SEND_EV_FAIL;
               sending_in = 1'b0;
            end
         end else begin
            send_timer_in = send_timer_ff + 16'd1;
         end
      end
      if (req.sent) begin
         if (!sending_ff) begin
            sending_in     = 1'b1;
            retry_count_in = 5'd0;
         end
         send_timer_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff     <= 1'b0;
         send_timer_ff  <= '0;
         retry_count_ff <= '0;
      end else begin
         sending_ff     <= sending_in;
         send_timer_ff  <= send_timer_in;
         retry_count_ff <= retry_count_in;
      end
   end

endmodule

/* rtl/serial_frame_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16: length-prefixed frame receiver with CRC-16
// Top level: configuration registers, receive and send sections, result
// register toward the consumer.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transaction is one event: a received byte (mode 0), a one
//   millisecond tick (mode 1) or a frame-sent notice (mode 2). Every
//   accepted event produces exactly one rsp_ transaction carrying reply,
//   frame-buffer write, frame status and send event fields.
//   The result of an event accepted at one edge is registered and
//   presented on rsp_ after that edge. Throughput is one event per cycle
//   while req_stall is low; state and CRC update in a single pass between
//   the input and the result register.
//   When the consumer holds rsp_stall, the result register keeps its
//   contents and req_stall is raised only while that register is full and
//   stalled; a waiting result does not block an event whose result can
//   replace it in the same cycle.
//   csr_ writes (index 0 min length, 1 max length, 2 timeout ticks,
//   3 retry limit) are always ready and belong in idle periods.
//   Reset (synchronous) clears all frame and send state, empties the
//   result register and restores the register defaults 10, 66, 1000, 3.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_code,
   output logic        rsp_write_valid,
   output logic [7:0]  rsp_write_index,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_frame_done,
   output logic        rsp_frame_good,
   output logic [1:0]  rsp_send_event,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import sfr_pkg::*;

   logic [7:0]  min_len_ff;
   logic [7:0]  max_len_ff;
   logic [15:0] timeout_ff;
   logic [3:0]  retry_lim_ff;

   logic           accept;
   logic           pos_zero;
   rx_result_type  rx_res;
   tx_request_type tx_req;
   logic [1:0]     send_event;

   rx_result_type  res_ff;
   logic [1:0]     send_event_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_LEN_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         retry_lim_ff <= RETRY_LIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_LEN:   min_len_ff   <= csr_data[7:0];
            CSR_MAX_LEN:   max_len_ff   <= csr_data[7:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data;
            CSR_RETRY_LIM: retry_lim_ff <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   sfr_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .rx_byte       (req_rx_byte),
      .min_len       (min_len_ff),
      .max_len       (max_len_ff),
      .timeout_ticks (timeout_ff),
      .pos_zero      (pos_zero),
      .result        (rx_res)
   );

   always_comb begin
      tx_req.tick   = accept && (req_mode == MODE_TICK);
      tx_req.sent   = accept && (req_mode == MODE_SENT);
      tx_req.resend = accept && (req_mode == MODE_BYTE) && pos_zero &&
                      (req_rx_byte == BYTE_RESEND);
      tx_req.ack    = accept && (req_mode == MODE_BYTE) && pos_zero &&
                      (req_rx_byte == BYTE_ACK);
   end

   sfr_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .req           (tx_req),
      .timeout_ticks (timeout_ff),
      .retry_limit   (retry_lim_ff),
      .send_event    (send_event)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff        <= rx_res;
         send_event_ff <= send_event;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_valid = res_ff.reply_valid;
   assign rsp_reply_code  = res_ff.reply_code;
   assign rsp_write_valid = res_ff.write_valid;
   assign rsp_write_index = res_ff.write_index;
   assign rsp_write_byte  = res_ff.write_byte;
   assign rsp_frame_done  = res_ff.frame_done;
   assign rsp_frame_good  = res_ff.frame_good;
   assign rsp_send_event  = send_event_ff;

   // every accepted transaction yields a result on the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_good_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_good) |-> (rsp_frame_done && rsp_reply_valid &&
         rsp_reply_code == REPLY_GOOD))
      else $error("frame_good without good completion");

   a_bad_start_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_valid && rsp_reply_code == REPLY_BAD_START)
         |-> (!rsp_write_valid && !rsp_frame_done))
      else $error("refused length byte was stored");

   a_done_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done && !rsp_frame_good) |-> (rsp_reply_valid &&
         (rsp_reply_code == REPLY_CRC_BAD || rsp_reply_code == REPLY_TIMEOUT)))
      else $error("abandoned frame without matching reply");

endmodule

/* dv/serial_frame_receiver_crc16_tb.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_tb: self-checking bench for the frame receiver
// Drives byte, tick and sent-notice events, predicts every result
// transaction (frame writes, CRC verdicts, bad starts, timeouts, send
// retries) and compares it field by field. Directed cases run first, among
// them a long receiver hold-off. Then comes random frame traffic under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16_tb;
   import sfr_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned IDLE_PCT    = 17;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned ITEM_TARGET = 1650;
   localparam int unsigned PHASE_ITEMS = 250;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_code;
      logic       write_valid;
      logic [7:0] write_index;
      logic [7:0] write_byte;
      logic       frame_done;
      logic       frame_good;
      logic [1:0] send_event;
   } frame_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode    = MODE_BYTE;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_code;
   logic        rsp_write_valid;
   logic [7:0]  rsp_write_index;
   logic [7:0]  rsp_write_byte;
   logic        rsp_frame_done;
   logic        rsp_frame_good;
   logic [1:0]  rsp_send_event;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = CSR_MIN_LEN;
   logic [15:0] csr_data    = 16'd0;

   // register copies
   logic [7:0]  cfg_min_len;
   logic [7:0]  cfg_max_len;
   logic [15:0] cfg_timeout;
   logic [3:0]  cfg_retry_lim;

   // receive and send state as the block should hold it
   logic [7:0]  rx_pos;
   logic [7:0]  rx_len;
   logic [15:0] rx_crc;
   logic [7:0]  crc_hi;
   logic        rx_active;
   logic [15:0] rx_timer;
   logic        tx_active;
   logic [15:0] tx_timer;
   logic [4:0]  tx_retries;

   frame_result_type frame_result_q[$];
   int unsigned   sent_count    = 0;
   int unsigned   checked_count = 0;
   int unsigned   fail_count    = 0;
   bit            idle_en       = 1'b1;
   bit            hold_request  = 1'b0;
   int unsigned   hold_left     = 0;

   serial_frame_receiver_crc16 u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_code  (rsp_reply_code),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_index (rsp_write_index),
      .rsp_write_byte  (rsp_write_byte),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_frame_good  (rsp_frame_good),
      .rsp_send_event  (rsp_send_event),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic frame_result_type next_frame_result(input logic [1:0] mode,
                                                          input logic [7:0] data);
      frame_result_type res;
      logic          build;
      logic [7:0]    body;
      logic [15:0]   rx_check;
      res = '0;
      case (mode)
         MODE_BYTE: begin
            build = 1'b1;
            if (rx_pos == 8'd0) begin
               build = 1'b0;
               if (data == BYTE_RESEND) begin
                  if (tx_active) res.send_event = SEND_EV_RESEND;
               end else if (data == BYTE_ACK) begin
                  if (tx_active) begin
                     res.send_event = SEND_EV_SUCCESS;
                     tx_active = 1'b0;
                  end
               end else if (data < LEN_FLOOR || data < cfg_min_len || data > cfg_max_len) begin
                  res.reply_valid = 1'b1;
                  res.reply_code  = REPLY_BAD_START;
               end else begin
                  rx_active = 1'b1;
                  rx_timer  = 16'd0;
                  rx_len    = data;
                  rx_crc    = 16'd0;
                  build     = 1'b1;
               end
            end
            if (build) begin
               body = rx_len - CRC_BYTES;
               res.write_valid = 1'b1;
               res.write_index = rx_pos;
               res.write_byte  = data;
               if (rx_pos < body) begin
                  rx_crc = crc16_update(rx_crc, data);
                  rx_pos = rx_pos + 8'd1;
               end else if (rx_pos == body) begin
                  crc_hi = data;
                  rx_pos = rx_pos + 8'd1;
               end else begin
                  rx_check = {crc_hi, data};
                  res.reply_valid = 1'b1;
                  res.reply_code  = (rx_check == rx_crc) ? REPLY_GOOD : REPLY_CRC_BAD;
                  res.frame_done  = 1'b1;
                  res.frame_good  = (rx_check == rx_crc);
                  rx_active = 1'b0;
                  rx_pos    = 8'd0;
               end
            end
         end
         MODE_TICK: begin
            if (rx_active) begin
               if (rx_timer >= cfg_timeout) begin
                  res.reply_valid = 1'b1;
                  res.reply_code  = REPLY_TIMEOUT;
                  res.frame_done  = 1'b1;
                  rx_active = 1'b0;
                  rx_pos    = 8'd0;
               end else begin
                  rx_timer = rx_timer + 16'd1;
               end
            end
            if (tx_active) begin
               if (tx_timer >= cfg_timeout) begin
                  tx_retries = tx_retries + 5'd1;
                  if (tx_retries <= {1'b0, cfg_retry_lim}) begin
                     res.send_event = SEND_EV_RESEND;
                     tx_timer = 16'd0;
                  end else begin
                     res.send_event = SEND_EV_FAIL;
                     tx_active = 1'b0;
                  end
               end else begin
                  tx_timer = tx_timer + 16'd1;
               end
            end
         end
         MODE_SENT: begin
            if (!tx_active) begin
               tx_active  = 1'b1;
               tx_retries = 5'd0;
            end
            tx_timer = 16'd0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result check first, then the prediction for this edge's input transaction
   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         cfg_min_len   = MIN_LEN_RESET;
         cfg_max_len   = MAX_LEN_RESET;
         cfg_timeout   = TIMEOUT_RESET;
         cfg_retry_lim = RETRY_LIM_RESET;
         rx_pos     = 8'd0;
         rx_len     = 8'd0;
         rx_crc     = 16'd0;
         crc_hi     = 8'd0;
         rx_active  = 1'b0;
         rx_timer   = 16'd0;
         tx_active  = 1'b0;
         tx_timer   = 16'd0;
         tx_retries = 5'd0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            got = {rsp_reply_valid, rsp_reply_code, rsp_write_valid, rsp_write_index,
                   rsp_write_byte, rsp_frame_done, rsp_frame_good, rsp_send_event};
            if (frame_result_q.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = frame_result_q.pop_front();
               check_field("reply_valid", want.reply_valid, got.reply_valid);
               check_field("reply_code",  want.reply_code,  got.reply_code);
               check_field("write_valid", want.write_valid, got.write_valid);
               check_field("write_index", want.write_index, got.write_index);
               check_field("write_byte",  want.write_byte,  got.write_byte);
               check_field("frame_done",  want.frame_done,  got.frame_done);
               check_field("frame_good",  want.frame_good,  got.frame_good);
               check_field("send_event",  want.send_event,  got.send_event);
            end
         end
         if (req_valid && !req_stall)
            frame_result_q.push_back(next_frame_result(req_mode, req_rx_byte));
      end
   end

   // consumer side: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin : watchdog
      int unsigned stale;
      stale = 0;
      while (stale < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            stale = 0;
         else
            stale++;
      end
      $display("[serial_frame_receiver_crc16] ERROR");
      $finish;
   end

   // valid stays high between back-to-back transactions
   task automatic put_event(input logic [1:0] mode, input logic [7:0] data);
      while (idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (checked_count != sent_count) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MIN_LEN:   cfg_min_len   = value[7:0];
         CSR_MAX_LEN:   cfg_max_len   = value[7:0];
         CSR_TIMEOUT:   cfg_timeout   = value;
         CSR_RETRY_LIM: cfg_retry_lim = value[3:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input int unsigned min_len, input int unsigned max_len,
                           input int unsigned timeout, input int unsigned retries);
      write_reg(CSR_MIN_LEN, 16'(min_len));
      write_reg(CSR_MAX_LEN, 16'(max_len));
      write_reg(CSR_TIMEOUT, 16'(timeout));
      write_reg(CSR_RETRY_LIM, 16'(retries));
   endtask

   // length byte, body, CRC high then low; markers put 0x00 and 0xFF in the body
   task automatic send_frame(input int unsigned len, input bit corrupt,
                             input int unsigned tick_pct, input bit markers);
      logic [15:0] crc;
      logic [7:0]  data;
      crc = 16'd0;
      for (int unsigned i = 0; i < len - 2; i++) begin
         if (i == 0) data = len[7:0];
         else if (markers && i == 1) data = 8'h00;
         else if (markers && i == 2) data = 8'hFF;
         else data = 8'($urandom_range(255));
         crc = crc16_update(crc, data);
         put_event(MODE_BYTE, data);
         if ($urandom_range(99) < tick_pct) put_event(MODE_TICK, 8'($urandom_range(255)));
      end
      if (corrupt) crc = crc ^ 16'(1 << $urandom_range(15));
      put_event(MODE_BYTE, crc[15:8]);
      put_event(MODE_BYTE, crc[7:0]);
   endtask

   task automatic run_episode();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_frame($urandom_range(cfg_min_len, cfg_max_len), $urandom_range(99) < 15, 8, 1'b0);
      end else if (pick < 62) begin
         // send supervision: a random run of ticks, at most 150, mixed with acknowledge and resend bytes
         put_event(MODE_SENT, 8'($urandom_range(255)));
         n = (int'(cfg_timeout) + 1) * (int'(cfg_retry_lim) + 2) + 2;
         if (n > 150) n = 150;
         n = $urandom_range(1, n);
         for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < 5)
               put_event(MODE_BYTE, $urandom_range(1) ? BYTE_ACK : BYTE_RESEND);
            else
               put_event(MODE_TICK, 8'($urandom_range(255)));
         end
      end else if (pick < 72) begin
         put_event(MODE_BYTE, $urandom_range(1) ? BYTE_ACK : BYTE_RESEND);
      end else if (pick < 82) begin
         n = $urandom_range(1, 40);
         for (int unsigned i = 0; i < n; i++) put_event(MODE_TICK, 8'($urandom_range(255)));
      end else if (pick < 90) begin
         put_event(MODE_BYTE, 8'($urandom_range(255)));
      end else if (pick < 95) begin
         put_event(MODE_SENT, 8'($urandom_range(255)));
      end else begin
         put_event(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
   endtask

   task automatic test_defaults();
      put_event(MODE_BYTE, BYTE_RESEND);      // nothing pending: ignored
      put_event(MODE_BYTE, BYTE_ACK);
      put_event(MODE_UNUSED, 8'hA5);
      put_event(MODE_BYTE, 8'd2);
      put_event(MODE_BYTE, MAX_LEN_RESET + 8'd1);
      send_frame(MIN_LEN_RESET, 1'b0, 0, 1'b1);
      put_event(MODE_SENT, 8'd0);
      put_event(MODE_TICK, 8'hFF);
      put_event(MODE_BYTE, BYTE_RESEND);
      put_event(MODE_BYTE, BYTE_ACK);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      set_regs(3, 3, 1, 0);
      put_event(MODE_BYTE, 8'd1);
      put_event(MODE_BYTE, 8'd4);
      send_frame(3, 1'b1, 0, 1'b0);
      // receive and send timeouts land on the same tick
      put_event(MODE_BYTE, 8'd3);
      put_event(MODE_SENT, 8'd0);
      put_event(MODE_TICK, 8'd0);
      put_event(MODE_TICK, 8'd0);
      put_event(MODE_SENT, 8'd0);
      put_event(MODE_TICK, 8'd0);
      put_event(MODE_TICK, 8'd0);
      wait_idle();
      write_reg(CSR_MIN_LEN, 16'd100);
      write_reg(CSR_MAX_LEN, 16'd50);
      put_event(MODE_BYTE, 8'd60);
      put_event(MODE_BYTE, 8'd100);
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_regs(3, 40, 4, 2);
      idle_en = 1'b0;
      hold_request = 1'b1;
      send_frame(8, 1'b0, 0, 1'b0);
      send_frame(12, 1'b1, 0, 1'b1);
      for (int unsigned i = 0; i < 16; i++) put_event(MODE_TICK, 8'($urandom_range(255)));
      wait_idle();
      idle_en = 1'b1;
   endtask

   task automatic test_long_frame();
      wait_idle();
      set_regs(255, 255, 65535, 15);
      put_event(MODE_SENT, 8'd0);
      send_frame(255, 1'b0, 2, 1'b1);
      put_event(MODE_BYTE, 8'd254);
      put_event(MODE_BYTE, BYTE_ACK);
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned lo;
      int unsigned start;
      phase = 0;
      while (sent_count < ITEM_TARGET) begin
         wait_idle();
         idle_en = (phase != 1);
         lo = $urandom_range(3, 12);
         set_regs(lo, lo + $urandom_range(0, 20),
                  (phase % 3 == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6),
                  $urandom_range(0, 15));
         start = sent_count;
         while (sent_count - start < PHASE_ITEMS && sent_count < ITEM_TARGET) run_episode();
         phase++;
      end
      wait_idle();
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_register_extremes();
      test_backpressure();
      test_long_frame();
      test_random_traffic();
      wait_idle();
      repeat (4) @(posedge clock);
      if (frame_result_q.size() != 0) begin
         $error("%0d expected results never arrived", frame_result_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("[serial_frame_receiver_crc16] OK");
      else
         $display("[serial_frame_receiver_crc16] ERROR");
      $finish;
   end

endmodule
